// ----- sv/two_button_debounce_chord_macros.svh -----
// assertion macros for the two-button debounce and chord block
// expects signals named clk and rst in the scope that uses them
`ifndef TWO_BUTTON_DEBOUNCE_CHORD_MACROS_SVH
`define TWO_BUTTON_DEBOUNCE_CHORD_MACROS_SVH

// same-cycle implication, quiet during reset
`define TBDC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, quiet during reset
`define TBDC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/tbdc_pkg.sv -----
// shared types and constants for the two-button debounce and chord block
// no dependencies
package tbdc_pkg;

  // default width of the timestamp arithmetic
  localparam int TIME_WIDTH_DEF = 32;

  // field and register widths
  localparam int NOW_W   = 32;
  localparam int DEB_W   = 16;
  localparam int CFG_W   = 16;
  localparam int CFG_IDX_W = 2;

  // reset value of the debounce time
  localparam logic [DEB_W-1:0] DEBOUNCE_RESET = DEB_W'(50);

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_MS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INVERT_FIRST  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INVERT_SECOND = 2'd2;

  // event codes
  typedef enum logic [1:0] {
    EV_NONE   = 2'd0,
    EV_FIRST  = 2'd1,
    EV_SECOND = 2'd2,
    EV_BOTH   = 2'd3
  } ev_code_t;

  // debounced level of one button before and after the current poll
  typedef struct packed {
    logic deb_old;
    logic deb_new;
  } btn_sts_t;

endpackage

// ----- sv/tbdc_debounce.sv -----
// per-button debouncer: raw history, debounced level and last change time
// depends on tbdc_pkg
module tbdc_debounce import tbdc_pkg::*; #(
  parameter int TIME_WIDTH = TIME_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  advance,
  input  logic                  raw,
  input  logic [TIME_WIDTH-1:0] now_time,
  input  logic [DEB_W-1:0]      debounce_ms,
  output btn_sts_t              sts
);

  localparam int CMP_W = (TIME_WIDTH > DEB_W) ? TIME_WIDTH : DEB_W;

  logic                  raw_prev;
  logic                  deb;
  logic [TIME_WIDTH-1:0] change_time;

  logic [TIME_WIDTH-1:0] elapsed;
  logic                  take;
  logic                  deb_next;

  // wrapping elapsed time against the debounce window
  always_comb begin
    elapsed  = now_time - change_time;
    take     = (raw != raw_prev) && (CMP_W'(elapsed) >= CMP_W'(debounce_ms));
    deb_next = take ? raw : deb;
  end

  assign sts.deb_old = deb;
  assign sts.deb_new = deb_next;

  // state update once per poll
  always_ff @(posedge clk) begin
    if (rst) begin
      raw_prev    <= 1'b0;
      deb         <= 1'b0;
      change_time <= '0;
    end else if (advance) begin
      raw_prev <= raw;
      deb      <= deb_next;
      if (take) begin
        change_time <= now_time;
      end
    end
  end

endmodule

// ----- sv/tbdc_chord.sv -----
// release and chord decision: single-press events and the chord flag
// depends on tbdc_pkg
module tbdc_chord import tbdc_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     advance,
  input  btn_sts_t first,
  input  btn_sts_t second,
  output ev_code_t ev,
  output logic     armed
);

  logic chord_armed;
  logic chord_armed_next;
  logic rel_first, rel_second, held_first, held_second, idle_both;

  // level shapes of the two debounced buttons
  always_comb begin
    rel_first   = first.deb_old && !first.deb_new;
    rel_second  = second.deb_old && !second.deb_new;
    held_first  = first.deb_old && first.deb_new;
    held_second = second.deb_old && second.deb_new;
    idle_both   = !first.deb_old && !first.deb_new && !second.deb_old && !second.deb_new;
  end

  // first release wins over second, both over chord completion
  always_comb begin
    ev               = EV_NONE;
    chord_armed_next = chord_armed;
    if (rel_first && !chord_armed) begin
      if (held_second) begin
        chord_armed_next = 1'b1;
      end else begin
        ev = EV_FIRST;
      end
    end else if (rel_second && !chord_armed) begin
      if (held_first) begin
        chord_armed_next = 1'b1;
      end else begin
        ev = EV_SECOND;
      end
    end else if (chord_armed && idle_both) begin
      chord_armed_next = 1'b0;
      ev               = EV_BOTH;
    end
  end

  assign armed = chord_armed;

  // chord flag
  always_ff @(posedge clk) begin
    if (rst) begin
      chord_armed <= 1'b0;
    end else if (advance) begin
      chord_armed <= chord_armed_next;
    end
  end

endmodule

// ----- sv/two_button_debounce_chord.sv -----
// top level of the two-button debounce and chord block
// depends on tbdc_pkg, tbdc_debounce, tbdc_chord and the macros header
//
// Takes one poll (two pin levels and a millisecond timestamp) per clock while
// the input is not stalled, and returns exactly one event code per poll, in
// order. A poll is captured in an input register, evaluated by a short update
// of the per-button debounce state and the chord flag, and its event is then
// registered in the result register once that register can take it. The result
// register is the only buffer on the output side: while it is stalled and full,
// the input register holds, and once the input register is also full the input
// stalls. Sustained rate is one poll per cycle while the output is not stalled.
// Configuration writes take effect at once and should be made with no poll in
// flight.
`include "two_button_debounce_chord_macros.svh"

module two_button_debounce_chord import tbdc_pkg::*; #(
  parameter int TIME_WIDTH = TIME_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  // configuration
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  // poll input
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 level_first,
  input  logic                 level_second,
  input  logic [NOW_W-1:0]     now_ms,
  // event output
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [1:0]           event_res
);

  logic [DEB_W-1:0] debounce_ms;
  logic             invert_first;
  logic             invert_second;

  logic             s1_valid;
  logic             s1_level_first;
  logic             s1_level_second;
  logic [NOW_W-1:0] s1_now;

  logic                  out_ready;
  logic                  s1_advance;
  logic [TIME_WIDTH-1:0] s1_time;
  btn_sts_t              sts_first;
  btn_sts_t              sts_second;
  ev_code_t              ev;
  logic                  armed;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ms   <= DEBOUNCE_RESET;
      invert_first  <= 1'b0;
      invert_second <= 1'b0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_DEBOUNCE_MS:   debounce_ms   <= cfg_data[DEB_W-1:0];
        REG_INVERT_FIRST:  invert_first  <= cfg_data[0];
        REG_INVERT_SECOND: invert_second <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // handshake between input register and result register
  assign out_ready  = !out_valid || !out_stall;
  assign s1_advance = s1_valid && out_ready;
  assign in_stall   = s1_valid && !out_ready;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_level_first  <= level_first;
      s1_level_second <= level_second;
      s1_now          <= now_ms;
    end
  end

  // timestamp taken modulo the time width
  generate
    if (TIME_WIDTH <= NOW_W) begin : g_time_narrow
      assign s1_time = s1_now[TIME_WIDTH-1:0];
    end else begin : g_time_wide
      assign s1_time = {{(TIME_WIDTH - NOW_W){1'b0}}, s1_now};
    end
  endgenerate

  // per-button debounce
  tbdc_debounce #(
    .TIME_WIDTH (TIME_WIDTH)
  ) u_deb_first (
    .clk         (clk),
    .rst         (rst),
    .advance     (s1_advance),
    .raw         (s1_level_first ^ invert_first),
    .now_time    (s1_time),
    .debounce_ms (debounce_ms),
    .sts         (sts_first)
  );

  tbdc_debounce #(
    .TIME_WIDTH (TIME_WIDTH)
  ) u_deb_second (
    .clk         (clk),
    .rst         (rst),
    .advance     (s1_advance),
    .raw         (s1_level_second ^ invert_second),
    .now_time    (s1_time),
    .debounce_ms (debounce_ms),
    .sts         (sts_second)
  );

  // event decision and chord flag
  tbdc_chord u_chord (
    .clk     (clk),
    .rst     (rst),
    .advance (s1_advance),
    .first   (sts_first),
    .second  (sts_second),
    .ev      (ev),
    .armed   (armed)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_ready) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      event_res <= ev;
    end
  end

  // checks on the chord flag
  `TBDC_ASSERT_NOW(a_both_needs_armed, s1_advance && ev == EV_BOTH, armed, "both event without armed chord")
  `TBDC_ASSERT_NEXT(a_both_clears_armed, s1_advance && ev == EV_BOTH, !armed, "chord flag kept after both event")
  `TBDC_ASSERT_NOW(a_armed_no_single, s1_advance && armed, ev == EV_NONE || ev == EV_BOTH, "single press while chord armed")
  `TBDC_ASSERT_NEXT(a_armed_holds, !s1_advance, $stable(armed), "chord flag moved without a poll")

endmodule
